### design/csfr_pkg.sv
// shared types and constants for the checksummed frame receiver
package csfr_pkg;

    // frame store depth and register defaults
    localparam int MAX_PAYLOAD   = 64;
    localparam int LEN_W         = 7;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 32;
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int TDATA_OUT_W   = 80;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd254;
    localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = 7'd16;
    localparam logic [LEN_W-1:0]  MIN_LEN = 7'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_RX,
        ST_READ,
        ST_SHOW
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic advance;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_done;
        logic sum_match;
        logic emit_last;
    } sts_t;

endpackage

### design/csfr_ram.sv
// generic single-port-write ram with registered read
module csfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/csfr_dp.sv
// datapath: config registers, frame store, checksum and counters
module csfr_dp #(
    parameter int MAX_PAYLOAD = csfr_pkg::MAX_PAYLOAD
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csfr_pkg::CFG_W-1:0]      cfg_data,
    input  logic [csfr_pkg::BYTE_W-1:0]     rx_byte,
    input  csfr_pkg::cmd_t                  cmd,
    output csfr_pkg::sts_t                  sts,
    output logic [csfr_pkg::BYTE_W-1:0]     out_byte,
    output logic [csfr_pkg::IDX_W-1:0]      byte_index,
    output logic                            frame_good,
    output logic [csfr_pkg::CNT_W-1:0]      good_frames,
    output logic [csfr_pkg::CNT_W-1:0]      missed_frames
);

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int LW = csfr_pkg::LEN_W;

    logic [csfr_pkg::BYTE_W-1:0] start_reg;
    logic [LW-1:0]               len_reg;
    logic [LW-1:0]               fill_reg;
    logic [csfr_pkg::BYTE_W-1:0] sum_reg;
    logic [csfr_pkg::CNT_W-1:0]  good_reg;
    logic [csfr_pkg::CNT_W-1:0]  missed_reg;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               last_reg;
    logic                        good_flag_reg;

    logic [LW-1:0]               len_eff;
    logic [LW-1:0]               fill_dec;
    logic [AW-1:0]               pos;
    logic                        idle;
    logic                        store_we;
    logic [csfr_pkg::BYTE_W-1:0] ram_rdata;

    // effective length, clamped to the legal range
    always_comb
    begin
        if (len_reg < csfr_pkg::MIN_LEN)
        begin
            len_eff = csfr_pkg::MIN_LEN;
        end
        else if (len_reg > LW'(MAX_PAYLOAD))
        begin
            len_eff = LW'(MAX_PAYLOAD);
        end
        else
        begin
            len_eff = len_reg;
        end
    end

    // store position of the incoming word
    assign idle     = (fill_reg == '0);
    assign fill_dec = fill_reg - LW'(1);
    assign pos      = (fill_dec >= LW'(MAX_PAYLOAD)) ? AW'(MAX_PAYLOAD - 1) : AW'(fill_dec);
    assign store_we = cmd.accept && !idle;

    // status towards the controller
    assign sts.frame_done = !idle && !(fill_reg < len_eff);
    assign sts.sum_match  = (sum_reg == rx_byte);
    assign sts.emit_last  = !good_flag_reg || (idx_reg == last_reg);

    csfr_ram #(
        .WIDTH (csfr_pkg::BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (pos),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // config, frame fill, checksum and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= csfr_pkg::START_BYTE_RST;
            len_reg       <= csfr_pkg::PAYLOAD_LEN_RST;
            fill_reg      <= '0;
            sum_reg       <= '0;
            good_reg      <= '0;
            missed_reg    <= '0;
            idx_reg       <= '0;
            last_reg      <= '0;
            good_flag_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    csfr_pkg::REG_START_BYTE:  start_reg <= cfg_data;
                    csfr_pkg::REG_PAYLOAD_LEN: len_reg   <= cfg_data[LW-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                if (idle)
                begin
                    if (rx_byte == start_reg)
                    begin
                        fill_reg <= LW'(1);
                        sum_reg  <= '0;
                    end
                end
                else if (!sts.frame_done)
                begin
                    fill_reg <= fill_reg + LW'(1);
                    sum_reg  <= sum_reg + rx_byte;
                end
                else
                begin
                    // frame complete: this word is the checksum
                    fill_reg      <= '0;
                    sum_reg       <= '0;
                    idx_reg       <= '0;
                    last_reg      <= pos;
                    good_flag_reg <= sts.sum_match;
                    if (sts.sum_match)
                    begin
                        good_reg <= good_reg + 1'b1;
                    end
                    else
                    begin
                        missed_reg <= missed_reg + 1'b1;
                    end
                end
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // result word fields
    assign out_byte      = good_flag_reg ? ram_rdata : '0;
    assign byte_index    = good_flag_reg ? csfr_pkg::IDX_W'(idx_reg) : '0;
    assign frame_good    = good_flag_reg;
    assign good_frames   = good_reg;
    assign missed_frames = missed_reg;

endmodule

### design/csfr_ctrl.sv
// controller: receive, store read and result handshake sequencing
module csfr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  csfr_pkg::sts_t sts,
    output csfr_pkg::cmd_t cmd
);

    csfr_pkg::state_t state_reg;
    csfr_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csfr_pkg::ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.accept  = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            csfr_pkg::ST_RX:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && sts.frame_done)
                begin
                    state_next = sts.sum_match ? csfr_pkg::ST_READ : csfr_pkg::ST_SHOW;
                end
            end
            csfr_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = csfr_pkg::ST_SHOW;
            end
            csfr_pkg::ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.emit_last)
                    begin
                        state_next = csfr_pkg::ST_RX;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = csfr_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = csfr_pkg::ST_RX;
            end
        endcase
    end

endmodule

### design/checksummed_frame_receiver.sv
// top level of the checksummed frame receiver
//
// Bytes are taken one per cycle while a frame is being received: an idle
// receiver drops everything but the start byte, then stores payload_length
// bytes, the last being the 8-bit additive checksum of the others. When a
// good frame of N bytes completes, input is held off while the N stored
// words are sent out, each held until m_axis_tready takes it and each
// waiting on its own registered read from the frame store, issued only
// once the word before it has been taken; a bad frame gives one report
// word in the cycle after its checksum byte. The counters in every result
// word already include the frame that produced it.
module checksummed_frame_receiver #(
    parameter int MAX_PAYLOAD = csfr_pkg::MAX_PAYLOAD
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [csfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csfr_pkg::CFG_W-1:0]          cfg_data,
    // received bytes
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] out_byte, [13:8] byte_index, [45:14] good_frames,
    // [77:46] missed_frames, [79:78] zero
    output logic [csfr_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,  // last_of_frame
    output logic                                m_axis_tuser   // frame_good
);

    csfr_pkg::cmd_t               cmd;
    csfr_pkg::sts_t               sts;
    logic [csfr_pkg::BYTE_W-1:0]  out_byte;
    logic [csfr_pkg::IDX_W-1:0]   byte_index;
    logic [csfr_pkg::CNT_W-1:0]   good_frames;
    logic [csfr_pkg::CNT_W-1:0]   missed_frames;

    csfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    csfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_byte       (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .out_byte      (out_byte),
        .byte_index    (byte_index),
        .frame_good    (m_axis_tuser),
        .good_frames   (good_frames),
        .missed_frames (missed_frames)
    );

    // pack the result word
    assign m_axis_tdata = {2'b00, missed_frames, good_frames, byte_index, out_byte};
    assign m_axis_tlast = sts.emit_last;

endmodule

### design/csfr_checker.sv
// port-level checks for the checksummed frame receiver
module csfr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [csfr_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // input is held off while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    // a bad-frame report is a single final word with zeroed byte and index fields
    a_bad_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[13:0] == 14'd0))
        else $error("malformed bad-frame report");

    // good frame words come with consecutive indexes
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
            !m_axis_tvalid ##1
            (m_axis_tvalid && m_axis_tuser
             && (m_axis_tdata[13:8] == 6'($past(m_axis_tdata[13:8], 2) + 6'd1))))
        else $error("payload index did not step by one");

endmodule

bind checksummed_frame_receiver csfr_checker u_csfr_checker (.*);

### bench/csfr_frame_checker.sv
// scoreboard for the checksummed frame receiver: predicts result words and compares them
module csfr_frame_checker
    import csfr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [TDATA_OUT_W-1:0]   m_axis_tdata,
    input  logic                     m_axis_tlast,
    input  logic                     m_axis_tuser,
    output int                       mismatches,
    output int                       words_due
);

    // one result word as the block should send it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  pos;
        logic              last;
        logic              good;
        logic [CNT_W-1:0]  good_n;
        logic [CNT_W-1:0]  missed_n;
    } frame_word_t;

    frame_word_t       frame_words_due[$];

    // shadow of the block's registers and frame state
    logic [BYTE_W-1:0] open_byte;
    logic [LEN_W-1:0]  frame_len_reg;
    logic [LEN_W-1:0]  fill;
    logic [BYTE_W-1:0] payload_copy [MAX_PAYLOAD];
    logic [BYTE_W-1:0] sum_so_far;
    logic [CNT_W-1:0]  good_total;
    logic [CNT_W-1:0]  missed_total;

    // fold one accepted byte into the frame state, queueing any words it releases
    task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
        int          span;
        int          slot;
        frame_word_t w;
        span = (frame_len_reg < MIN_LEN) ? int'(MIN_LEN) :
               (frame_len_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(frame_len_reg);
        if (fill == '0)
        begin
            if (b == open_byte)
            begin
                fill       = 7'd1;
                sum_so_far = '0;
            end
            return;
        end
        slot = int'(fill) - 1;
        if (slot >= MAX_PAYLOAD)
            slot = MAX_PAYLOAD - 1;
        payload_copy[slot] = b;
        fill = fill + 7'd1;
        if (int'(fill) - 1 < span)
        begin
            sum_so_far = sum_so_far + b;
            return;
        end
        // frame closed: this byte is the checksum
        span = slot + 1;
        fill = '0;
        if (sum_so_far == b)
        begin
            good_total = good_total + 1;
            for (int i = 0; i < span; i++)
            begin
                w.data     = payload_copy[i];
                w.pos      = i[IDX_W-1:0];
                w.last     = (i + 1 == span);
                w.good     = 1'b1;
                w.good_n   = good_total;
                w.missed_n = missed_total;
                frame_words_due.push_back(w);
            end
        end
        else
        begin
            missed_total = missed_total + 1;
            w.data     = '0;
            w.pos      = '0;
            w.last     = 1'b1;
            w.good     = 1'b0;
            w.good_n   = good_total;
            w.missed_n = missed_total;
            frame_words_due.push_back(w);
        end
        sum_so_far = '0;
    endtask

    task automatic flag_field(input string what, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t w;
        if (!rst_n)
        begin
            open_byte     = START_BYTE_RST;
            frame_len_reg = PAYLOAD_LEN_RST;
            fill          = '0;
            sum_so_far    = '0;
            good_total    = '0;
            missed_total  = '0;
            mismatches    = 0;
            frame_words_due.delete();
            words_due    <= 0;
        end
        else
        begin
            // result words are checked first: none can stem from this edge's input
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (frame_words_due.size() == 0)
                begin
                    $display("%0t: result word %0h with nothing expected", $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    w = frame_words_due.pop_front();
                    flag_field("out_byte", CNT_W'(w.data), CNT_W'(m_axis_tdata[7:0]));
                    flag_field("byte_index", CNT_W'(w.pos), CNT_W'(m_axis_tdata[13:8]));
                    flag_field("good_frames", w.good_n, m_axis_tdata[45:14]);
                    flag_field("missed_frames", w.missed_n, m_axis_tdata[77:46]);
                    flag_field("tdata padding", '0, CNT_W'(m_axis_tdata[79:78]));
                    flag_field("last_of_frame", CNT_W'(w.last), CNT_W'(m_axis_tlast));
                    flag_field("frame_good", CNT_W'(w.good), CNT_W'(m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_rx_byte(s_axis_tdata);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_BYTE:  open_byte     = cfg_data;
                    REG_PAYLOAD_LEN: frame_len_reg = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            words_due <= frame_words_due.size();
        end
    end

endmodule

### bench/tb_checksummed_frame_receiver.sv
// stimulus and verdict for the checksummed frame receiver
module tb_checksummed_frame_receiver;
    import csfr_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int TARGET_WORDS  = 350;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    int          mismatches;
    int          words_due;
    int          cycle_count = 0;
    int          gap_pct;
    int          stall_pct;
    int          holds_asked;
    logic [7:0]  cur_start;
    int          cur_len;
    int          words_sent;
    int          frames_sent;
    int          settings_used;

    always #4 clk = ~clk;

    checksummed_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    csfr_frame_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .words_due     (words_due)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_checksummed_frame_receiver NOT OK");
            $finish;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left     = 0;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (holds_done != holds_asked)
            begin
                m_axis_tready <= 1'b0;
                hold_left  = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // offer one received byte, with random gaps, until the block takes it
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // stop sending, wait for every outstanding word, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_START_BYTE)
            cur_start = val;
        else
            cur_len = (val[6:0] < MIN_LEN) ? int'(MIN_LEN) :
                      (val[6:0] > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(val[6:0]);
    endtask

    // noise that cannot open a frame, start byte, random payload, checksum
    task automatic send_frame(input bit corrupt, input int noise);
        logic [7:0] sum;
        logic [7:0] b;
        repeat (noise)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == cur_start)
                b = ~b;
            send_word(b);
        end
        send_word(cur_start);
        sum = '0;
        repeat (cur_len - 1)
        begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_word(b);
        end
        if (corrupt)
            sum = sum + 8'($urandom_range(1, 255));
        send_word(sum);
        frames_sent++;
    endtask

    initial
    begin
        int          k;
        int          n_frames;
        logic [7:0]  start_pick;
        logic [7:0]  len_pick;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_START_BYTE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        gap_pct       = 37;
        stall_pct     = 37;
        holds_asked   = 0;
        cur_start     = START_BYTE_RST;
        cur_len       = int'(PAYLOAD_LEN_RST);
        words_sent    = 0;
        frames_sent   = 0;
        settings_used = 1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults straight after reset
        send_frame(1'b0, 1);

        // shortest frames: all-ones payload, start byte inside a frame, bad checksum
        write_reg(REG_START_BYTE, 8'h00);
        write_reg(REG_PAYLOAD_LEN, 8'd2);
        send_word(8'h00); send_word(8'hFF); send_word(8'hFF);
        send_word(8'h00); send_word(8'h00); send_word(8'h00);
        send_word(8'h00); send_word(8'h12); send_word(8'h34);

        // lengths below the minimum act as two
        write_reg(REG_PAYLOAD_LEN, 8'd0);
        send_frame(1'b0, 0);
        write_reg(REG_PAYLOAD_LEN, 8'd1);
        send_frame(1'b1, 0);

        // length cut short mid-frame: the next byte closes it as checksum
        write_reg(REG_PAYLOAD_LEN, 8'd5);
        send_word(8'h00); send_word(8'h11); send_word(8'h22);
        write_reg(REG_PAYLOAD_LEN, 8'd2);
        send_word(8'h33);

        // length raised mid-frame
        send_word(8'h00); send_word(8'hA5);
        write_reg(REG_PAYLOAD_LEN, 8'd4);
        send_word(8'h5A); send_word(8'h01); send_word(8'h00);

        // all-ones start byte, near miss ignored while idle
        write_reg(REG_START_BYTE, 8'hFF);
        write_reg(REG_PAYLOAD_LEN, 8'd3);
        send_word(8'hFE); send_word(8'hFF); send_word(8'h7F);
        send_word(8'h80); send_word(8'hFF);
        settings_used += 7;

        // random frames under a rotating set of register settings
        k = 0;
        while (words_sent < TARGET_WORDS)
        begin
            start_pick = 8'($urandom_range(0, 255));
            case (k % 6)
                0:       begin start_pick = 8'hFF; len_pick = 8'($urandom_range(2, 8)); end
                1:       len_pick = 8'($urandom_range(9, 20));
                2:       len_pick = 8'd64;
                3:       begin start_pick = 8'h00; len_pick = 8'($urandom_range(0, 1)); end
                4:       len_pick = 8'd127;
                default: len_pick = 8'($urandom_range(2, 6));
            endcase
            write_reg(REG_START_BYTE, start_pick);
            write_reg(REG_PAYLOAD_LEN, len_pick);
            settings_used++;
            // long receiver hold-off while frames keep coming
            if (k == 0)
                holds_asked++;
            // a stretch with no idling on either side
            if (k == 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            n_frames = (cur_len >= 40) ? $urandom_range(1, 2) : $urandom_range(5, 9);
            repeat (n_frames)
            begin
                if (words_sent < TARGET_WORDS)
                begin
                    // occasional raw noise that may open or disturb a frame
                    if ($urandom_range(0, 9) == 0)
                        repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)));
                    send_frame($urandom_range(0, 99) < 20, $urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0)
                        settle();
                end
            end
            gap_pct   = 37;
            stall_pct = 37;
            k++;
        end

        settle();
        $display("covered %0d received words, %0d framed sequences, %0d register settings",
                 words_sent, frames_sent, settings_used);
        $display("including stalls, a long result hold-off and mid-frame length changes");
        if (mismatches == 0 && words_due == 0)
            $display("tb_checksummed_frame_receiver OK");
        else
            $display("tb_checksummed_frame_receiver NOT OK");
        $finish;
    end

endmodule

### files.f
design/csfr_pkg.sv
design/csfr_ram.sv
design/csfr_dp.sv
design/csfr_ctrl.sv
design/checksummed_frame_receiver.sv
design/csfr_checker.sv
bench/csfr_frame_checker.sv
bench/tb_checksummed_frame_receiver.sv
